>>> hdl/sobel_pkg.sv
`default_nettype none
package sobel_pkg;
    localparam int MAX_WIDTH = 1024;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int MAX_HEIGHT = 4096;
    localparam int IN_ROW_MAX = 8191;
    localparam int QUEUE_DEPTH = 4;

    localparam logic CFG_FRAME_WIDTH = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       last_of_frame;
    } pixel_out_t;

    // Job handed from front to back: masked 3x3 window and frame end flag.
    typedef struct packed {
        logic [8:0][23:0] taps;
        logic             last;
    } sobel_job_t;
endpackage
`default_nettype wire

>>> hdl/sobel_front.sv
`default_nettype none
module sobel_front
    import sobel_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [0:0] cfg_index,
    input  wire logic [12:0] cfg_data,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire pixel_in_t  in_item,
    output logic            job_valid,
    output sobel_job_t      job,
    input  wire logic       job_full
);
    logic [10:0] frame_width_reg;
    logic [12:0] frame_height_reg;
    logic [23:0] older_mem [MAX_WIDTH];
    logic [23:0] newer_mem [MAX_WIDTH];

    // stage 1: line buffer read
    logic             s1_valid_reg;
    logic [23:0]      s1_pix_reg;
    logic             s1_emit_reg;
    logic [COL_W-1:0] s1_ocol_reg;
    logic [11:0]      s1_orow_reg;
    logic             s1_last_reg;
    logic [23:0]      top_rd_reg;
    logic [23:0]      mid_rd_reg;

    logic [8:0][23:0] win_reg;
    logic [8:0][23:0] win_next;

    logic [COL_W-1:0] in_col_reg;
    logic [12:0]      in_row_reg;
    logic [COL_W-1:0] out_col_reg;
    logic [11:0]      out_row_reg;

    logic [COL_W:0]   w;
    logic [12:0]      h;
    logic [COL_W-1:0] wl;
    logic [11:0]      hl;
    logic [COL_W-1:0] icol;
    logic [COL_W-1:0] ocol;
    logic             accept;
    logic             emit;
    logic             last;
    logic [23:0]      pix;
    logic             col_wrap;

    always_comb
    begin
        if (frame_width_reg == 11'd0)
            w = (COL_W+1)'(1);
        else if (frame_width_reg > 11'(MAX_WIDTH))
            w = (COL_W+1)'(MAX_WIDTH);
        else
            w = (COL_W+1)'(frame_width_reg);
        if (frame_height_reg == 13'd0)
            h = 13'd1;
        else if (frame_height_reg > 13'(MAX_HEIGHT))
            h = 13'(MAX_HEIGHT);
        else
            h = frame_height_reg;
        wl = COL_W'(w - (COL_W+1)'(1));
        hl = 12'(h - 13'd1);
        icol = ((COL_W+1)'(in_col_reg) >= w) ? '0 : in_col_reg;
        ocol = ((COL_W+1)'(out_col_reg) >= w) ? wl : out_col_reg;
        pix = in_item.kind ? 24'd0 : {in_item.red_in, in_item.green_in, in_item.blue_in};
        emit = (in_row_reg >= 13'd2) || (in_row_reg == 13'd1 && icol != '0);
        last = (out_row_reg >= hl) && (ocol == wl);
        col_wrap = ((COL_W+1)'(icol) + (COL_W+1)'(1)) >= w;
    end

    // The input stalls only while the queue is almost full.
    assign in_stall = job_full;
    assign accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            top_rd_reg <= older_mem[icol];
            mid_rd_reg <= newer_mem[icol];
            older_mem[icol] <= newer_mem[icol];
            newer_mem[icol] <= pix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= 11'd640;
            frame_height_reg <= 13'd480;
            in_col_reg       <= '0;
            in_row_reg       <= '0;
            out_col_reg      <= '0;
            out_row_reg      <= '0;
            s1_valid_reg     <= 1'b0;
            win_reg          <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == CFG_FRAME_WIDTH)
                    frame_width_reg <= cfg_data[10:0];
                else
                    frame_height_reg <= cfg_data;
            end
            s1_valid_reg <= accept;
            if (s1_valid_reg)
                win_reg <= win_next;
            if (accept)
            begin
                s1_pix_reg  <= pix;
                s1_emit_reg <= emit;
                s1_ocol_reg <= ocol;
                s1_orow_reg <= out_row_reg;
                s1_last_reg <= last;
                if (emit && last)
                begin
                    in_col_reg  <= '0;
                    in_row_reg  <= '0;
                    out_col_reg <= '0;
                    out_row_reg <= '0;
                end
                else
                begin
                    if (col_wrap)
                    begin
                        in_col_reg <= '0;
                        if (in_row_reg < 13'(IN_ROW_MAX))
                            in_row_reg <= in_row_reg + 13'd1;
                    end
                    else
                    begin
                        in_col_reg <= icol + COL_W'(1);
                    end
                    if (emit)
                    begin
                        if (ocol == wl)
                        begin
                            out_col_reg <= '0;
                            out_row_reg <= out_row_reg + 12'd1;
                        end
                        else
                        begin
                            out_col_reg <= ocol + COL_W'(1);
                        end
                    end
                    else
                    begin
                        out_col_reg <= ocol;
                    end
                end
            end
        end
    end

    // Window shift uses the registered line buffer reads from stage 1.
    always_comb
    begin
        win_next = win_reg;
        for (int r = 0; r < 3; r++)
        begin
            win_next[r*3]   = win_reg[r*3+1];
            win_next[r*3+1] = win_reg[r*3+2];
        end
        win_next[2] = top_rd_reg;
        win_next[5] = mid_rd_reg;
        win_next[8] = s1_pix_reg;
    end

    always_comb
    begin
        job.taps = win_next;
        if (s1_ocol_reg == '0)
        begin
            job.taps[0] = '0; job.taps[3] = '0; job.taps[6] = '0;
        end
        if (s1_ocol_reg == wl)
        begin
            job.taps[2] = '0; job.taps[5] = '0; job.taps[8] = '0;
        end
        if (s1_orow_reg == 12'd0)
        begin
            job.taps[0] = '0; job.taps[1] = '0; job.taps[2] = '0;
        end
        if (s1_orow_reg >= hl)
        begin
            job.taps[6] = '0; job.taps[7] = '0; job.taps[8] = '0;
        end
        job.last = s1_last_reg;
        job_valid = s1_valid_reg && s1_emit_reg;
    end
endmodule
`default_nettype wire

>>> hdl/sobel_queue.sv
`default_nettype none
module sobel_queue
    import sobel_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       wr_valid,
    input  wire sobel_job_t wr_data,
    output logic            almost_full,
    output logic            rd_valid,
    output sobel_job_t      rd_data,
    input  wire logic       rd_take
);
    localparam int PW = $clog2(QUEUE_DEPTH);
    sobel_job_t    slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wp_reg;
    logic [PW-1:0] rp_reg;
    logic [PW:0]   cnt_reg;
    logic          do_rd;

    assign rd_valid = cnt_reg != '0;
    assign rd_data = slot_reg[rp_reg];
    assign do_rd = rd_take && rd_valid;
    // One in flight upstream (stage 1): keep two slots of slack.
    assign almost_full = cnt_reg >= (PW+1)'(QUEUE_DEPTH - 2);

    always_ff @(posedge clk)
    begin
        if (wr_valid)
            slot_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_valid)
                wp_reg <= wp_reg + PW'(1);
            if (do_rd)
                rp_reg <= rp_reg + PW'(1);
            cnt_reg <= cnt_reg + (PW+1)'(wr_valid) - (PW+1)'(do_rd);
        end
    end
endmodule
`default_nettype wire

>>> hdl/sobel_back.sv
`default_nettype none
module sobel_back
    import sobel_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       job_valid,
    input  wire sobel_job_t job,
    output logic            job_take,
    output logic            out_valid,
    output pixel_out_t      out_item,
    input  wire logic       out_stall
);
    typedef enum logic [1:0] {IDLE, GRAD, ROOT, SHOW} state_t;
    state_t state_reg;

    logic [8:0][23:0]  taps_reg;
    logic              last_reg;
    logic [2:0][15:0]  n_reg;
    logic [2:0][16:0]  rem_reg;
    logic [2:0][8:0]   res_reg;
    logic [3:0]        step_reg;
    logic [2:0][7:0]   mag_reg;

    logic [2:0][15:0]  n_calc;
    logic [2:0][16:0]  rem_next;
    logic [2:0][8:0]   res_next;
    logic [2:0][7:0]   mag_calc;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            logic signed [11:0] gx;
            logic signed [11:0] gy;
            logic [23:0] sq;
            logic [7:0] v [9];
            for (int i = 0; i < 9; i++)
                v[i] = taps_reg[i][c*8 +: 8];
            gx = $signed({4'd0, v[2]}) + $signed({3'd0, v[5], 1'b0}) + $signed({4'd0, v[8]})
               - $signed({4'd0, v[0]}) - $signed({3'd0, v[3], 1'b0}) - $signed({4'd0, v[6]});
            gy = $signed({4'd0, v[6]}) + $signed({3'd0, v[7], 1'b0}) + $signed({4'd0, v[8]})
               - $signed({4'd0, v[0]}) - $signed({3'd0, v[1], 1'b0}) - $signed({4'd0, v[2]});
            sq = 24'(gx * gx) + 24'(gy * gy);
            // anything past 16 bits saturates the result anyway
            n_calc[c] = (sq > 24'd65535) ? 16'hFFFF : sq[15:0];
        end
    end

    // Restoring square root, one result bit per cycle per channel.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            logic [18:0] trial;
            logic [18:0] r2;
            r2 = {rem_reg[c], n_reg[c][15:14]};
            trial = {8'd0, res_reg[c], 2'b01};
            if (r2 >= trial)
            begin
                rem_next[c] = 17'(r2 - trial);
                res_next[c] = {res_reg[c][7:0], 1'b1};
            end
            else
            begin
                rem_next[c] = 17'(r2);
                res_next[c] = {res_reg[c][7:0], 1'b0};
            end
            // round up when remainder exceeds s, saturate at 255
            if (res_reg[c] > 9'd255 || (res_reg[c] == 9'd255 && rem_reg[c] > 17'd255))
                mag_calc[c] = 8'd255;
            else if (rem_reg[c] > 17'(res_reg[c]))
                mag_calc[c] = 8'(res_reg[c] + 9'd1);
            else
                mag_calc[c] = res_reg[c][7:0];
        end
    end

    assign job_take = (state_reg == IDLE);
    assign out_valid = (state_reg == SHOW);
    assign out_item = '{red_out: mag_reg[2], green_out: mag_reg[1],
                        blue_out: mag_reg[0], last_of_frame: last_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
        end
        else
        begin
            unique case (state_reg)
                IDLE:
                begin
                    if (job_valid)
                    begin
                        taps_reg <= job.taps;
                        last_reg <= job.last;
                        state_reg <= GRAD;
                    end
                end
                GRAD:
                begin
                    n_reg <= n_calc;
                    rem_reg <= '0;
                    res_reg <= '0;
                    step_reg <= '0;
                    state_reg <= ROOT;
                end
                ROOT:
                begin
                    if (step_reg == 4'd8)
                    begin
                        mag_reg <= mag_calc;
                        state_reg <= SHOW;
                    end
                    else
                    begin
                        rem_reg <= rem_next;
                        res_reg <= res_next;
                        for (int c = 0; c < 3; c++)
                            n_reg[c] <= {n_reg[c][13:0], 2'b00};
                        step_reg <= step_reg + 4'd1;
                    end
                end
                SHOW:
                begin
                    if (!out_stall)
                        state_reg <= IDLE;
                end
                default: state_reg <= IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> hdl/sobel_edge_magnitude_rgb.sv
// Path: a result passes front stage 1, the job queue and back states GRAD, ROOT,
// SHOW. Results are paced by the 8-step square root in the back end, which takes
// no new job until done; resultless items are taken one per cycle unless stalled.
// Reset: asynchronous, active low; clears counters, window, queue and registers
// to 640x480. Line buffers are not cleared.
`default_nettype none
module sobel_edge_magnitude_rgb
    import sobel_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [12:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire pixel_in_t   in_item,
    output logic             out_valid,
    input  wire logic        out_stall,
    output pixel_out_t       out_item
);
    logic       fj_valid;
    sobel_job_t fj;
    logic       q_full;
    logic       qv;
    sobel_job_t qd;
    logic       q_take;

    sobel_front u_front (
        .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .in_valid, .in_stall, .in_item,
        .job_valid(fj_valid), .job(fj), .job_full(q_full)
    );

    sobel_queue u_queue (
        .clk, .rst_n, .wr_valid(fj_valid), .wr_data(fj), .almost_full(q_full),
        .rd_valid(qv), .rd_data(qd), .rd_take(q_take)
    );

    sobel_back u_back (
        .clk, .rst_n, .job_valid(qv), .job(qd), .job_take(q_take),
        .out_valid, .out_item, .out_stall
    );
endmodule
`default_nettype wire
